@@ rtl/core/klfp_pkg.sv @@
package klfp_pkg;

    localparam int unsigned MAX_TOKEN_BYTES = 16;
    localparam int unsigned MAX_PAYLOAD     = 16777215;

    localparam int unsigned TOK_W   = $clog2(MAX_TOKEN_BYTES + 1);
    localparam int unsigned LEN_W   = $clog2(MAX_PAYLOAD + 1);
    localparam int unsigned TICK_W  = 20;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned ADDR_W  = 4;

    localparam int unsigned NUM_KW     = 6;
    localparam int unsigned KW_MAX_LEN = 9;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [TICK_W-1:0] TRANSFER_TIMEOUT_RST = TICK_W'(30 * 1000);
    localparam logic [TICK_W-1:0] PONG_TIMEOUT_RST     = TICK_W'(60 * 1000);
    localparam logic [TICK_W-1:0] PING_INTERVAL_RST    = TICK_W'(5 * 1000);

    localparam logic [KW_MAX_LEN*8-1:0] KW_TEXT [NUM_KW] = '{
        (KW_MAX_LEN*8)'("PING "),
        (KW_MAX_LEN*8)'("PONG "),
        (KW_MAX_LEN*8)'("MESSAGE "),
        (KW_MAX_LEN*8)'("GREETING "),
        (KW_MAX_LEN*8)'("BINARY "),
        (KW_MAX_LEN*8)'("FILENAME ")
    };
    localparam int unsigned KW_LEN [NUM_KW] = '{5, 5, 8, 9, 7, 9};

    localparam logic [2:0] KIND_PING     = 3'd0;
    localparam logic [2:0] KIND_PONG     = 3'd1;
    localparam logic [2:0] KIND_MESSAGE  = 3'd2;
    localparam logic [2:0] KIND_GREETING = 3'd3;
    localparam logic [2:0] KIND_BINARY   = 3'd4;
    localparam logic [2:0] KIND_FILENAME = 3'd5;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_READY = 3'd1,
        EV_PONG  = 3'd2,
        EV_PING  = 3'd3,
        EV_ABORT = 3'd4
    } event_t;

    typedef enum logic [1:0] {
        LINK_WAIT  = 2'd0,
        LINK_READY = 2'd1,
        LINK_DEAD  = 2'd2
    } link_phase_t;

    typedef enum logic [1:0] {
        PH_KEY  = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2
    } parse_phase_t;

    typedef enum logic [1:0] {
        REG_TRANSFER_TIMEOUT = 2'd0,
        REG_PONG_TIMEOUT     = 2'd1,
        REG_PING_INTERVAL    = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [TICK_W-1:0] transfer_timeout_ticks;
        logic [TICK_W-1:0] pong_timeout_ticks;
        logic [TICK_W-1:0] ping_interval_ticks;
    } cfg_t;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
    } in_item_t;

    function automatic logic [7:0] kw_char(input int unsigned k, input logic [TOK_W-1:0] pos);
        int unsigned sel;
        sel = KW_LEN[k] - 1 - int'(pos);
        return KW_TEXT[k][sel*8 +: 8];
    endfunction

endpackage

@@ rtl/core/klfp_cfg_regs.sv @@
module klfp_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [klfp_pkg::ADDR_W-1:0]  paddr,
    input  logic [klfp_pkg::DATA_W-1:0]  pwdata,
    output logic [klfp_pkg::DATA_W-1:0]  prdata,
    output klfp_pkg::cfg_t               cfg
);
    import klfp_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_index_t index;
    logic       wr_en;

    assign index = reg_index_t'(paddr[ADDR_W-1:2]);
    assign wr_en = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (index)
                REG_TRANSFER_TIMEOUT: cfg_next.transfer_timeout_ticks = pwdata[TICK_W-1:0];
                REG_PONG_TIMEOUT:     cfg_next.pong_timeout_ticks     = pwdata[TICK_W-1:0];
                REG_PING_INTERVAL:    cfg_next.ping_interval_ticks    = pwdata[TICK_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_TRANSFER_TIMEOUT: prdata = DATA_W'(cfg_reg.transfer_timeout_ticks);
            REG_PONG_TIMEOUT:     prdata = DATA_W'(cfg_reg.pong_timeout_ticks);
            REG_PING_INTERVAL:    prdata = DATA_W'(cfg_reg.ping_interval_ticks);
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.transfer_timeout_ticks <= TRANSFER_TIMEOUT_RST;
            cfg_reg.pong_timeout_ticks     <= PONG_TIMEOUT_RST;
            cfg_reg.ping_interval_ticks    <= PING_INTERVAL_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/core/klfp_in_reg.sv @@
module klfp_in_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                op,
    input  logic [7:0]          rx_byte,
    output logic                item_valid,
    output klfp_pkg::in_item_t  item,
    input  logic                take
);
    import klfp_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     load;

    assign in_stall = valid_reg && !take;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.op      <= op;
            item_reg.rx_byte <= rx_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ rtl/core/klfp_parser.sv @@
module klfp_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  klfp_pkg::in_item_t  item,
    output logic                take,
    input  klfp_pkg::cfg_t      cfg,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                payload_valid,
    output logic [7:0]          payload_byte,
    output logic [2:0]          frame_kind,
    output logic                last_byte,
    output logic [2:0]          event_res
);
    import klfp_pkg::*;

    link_phase_t       link_phase_reg,  link_phase_next;
    parse_phase_t      parse_phase_reg, parse_phase_next;
    logic [NUM_KW-1:0] cand_reg,        cand_next;
    logic [TOK_W-1:0]  token_count_reg, token_count_next;
    logic [2:0]        frame_type_reg,  frame_type_next;
    logic [LEN_W-1:0]  length_reg,      length_next;
    logic [LEN_W-1:0]  bytes_left_reg,  bytes_left_next;
    logic [TICK_W-1:0] idle_ticks_reg,  idle_ticks_next;
    logic [TICK_W-1:0] ping_ticks_reg,  ping_ticks_next;
    logic [TICK_W-1:0] pong_age_reg,    pong_age_next;

    logic              out_valid_reg,   out_valid_next;
    logic              pvalid_reg,      pvalid_next;
    logic [7:0]        pbyte_reg,       pbyte_next;
    logic [2:0]        kind_reg,        kind_next;
    logic              last_reg,        last_next;
    event_t            event_reg,       ev;

    logic              is_byte;
    logic              is_space;
    logic              is_digit;
    logic [NUM_KW-1:0] keep;
    logic              kw_found;
    logic [2:0]        kw_kind;
    logic [TOK_W-1:0]  tok_inc;
    logic [LEN_W+3:0]  len_ext;
    logic [LEN_W+3:0]  len_new;
    logic [LEN_W-1:0]  left_dec;
    logic              partial;
    logic [TICK_W-1:0] idle_inc;
    logic [TICK_W-1:0] ping_inc;
    logic [TICK_W-1:0] pong_inc;
    logic              data_byte;

    assign take = item_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        is_byte  = (item.op == OP_BYTE);
        is_space = (item.rx_byte == CHAR_SPACE);
        is_digit = (item.rx_byte >= CHAR_ZERO) && (item.rx_byte <= CHAR_NINE);

        for (int unsigned k = 0; k < NUM_KW; k++)
        begin
            keep[k] = cand_reg[k] && (int'(token_count_reg) < int'(KW_LEN[k]))
                      && (kw_char(k, token_count_reg) == item.rx_byte);
        end
        kw_found = |keep;
        kw_kind  = KIND_PING;
        for (int k = NUM_KW - 1; k >= 0; k--)
        begin
            if (keep[k])
            begin
                kw_kind = 3'(k);
            end
        end

        tok_inc  = token_count_reg + 1'b1;
        len_ext  = (LEN_W+4)'(length_reg);
        len_new  = (len_ext << 3) + (len_ext << 1)
                   + (LEN_W+4)'(item.rx_byte[3:0]);
        left_dec = bytes_left_reg - 1'b1;

        partial  = (parse_phase_reg != PH_KEY) || (token_count_reg != '0);
        idle_inc = (&idle_ticks_reg) ? idle_ticks_reg : idle_ticks_reg + 1'b1;
        ping_inc = (&ping_ticks_reg) ? ping_ticks_reg : ping_ticks_reg + 1'b1;
        pong_inc = (&pong_age_reg)   ? pong_age_reg   : pong_age_reg + 1'b1;
    end

    always_comb
    begin
        ev = EV_NONE;
        if (link_phase_reg == LINK_DEAD)
        begin
            ev = EV_NONE;
        end
        else if (is_byte)
        begin
            unique case (parse_phase_reg)
                PH_KEY:
                begin
                    if (is_space)
                    begin
                        if (!kw_found
                            || (link_phase_reg == LINK_WAIT && kw_kind != KIND_GREETING))
                        begin
                            ev = EV_ABORT;
                        end
                    end
                    else if (tok_inc >= TOK_W'(MAX_TOKEN_BYTES))
                    begin
                        ev = EV_ABORT;
                    end
                end
                PH_LEN:
                begin
                    if (is_space)
                    begin
                        if (length_reg == '0)
                        begin
                            ev = EV_ABORT;
                        end
                    end
                    else if (!is_digit || len_new > (LEN_W+4)'(MAX_PAYLOAD)
                             || tok_inc >= TOK_W'(MAX_TOKEN_BYTES))
                    begin
                        ev = EV_ABORT;
                    end
                end
                PH_DATA:
                begin
                    if (left_dec == '0)
                    begin
                        if (link_phase_reg == LINK_WAIT)
                        begin
                            ev = EV_READY;
                        end
                        else if (frame_type_reg == KIND_PING)
                        begin
                            ev = EV_PONG;
                        end
                    end
                end
                default:
                begin
                    ev = EV_NONE;
                end
            endcase
        end
        else
        begin
            if (partial && idle_inc >= cfg.transfer_timeout_ticks)
            begin
                ev = EV_ABORT;
            end
            else if (link_phase_reg == LINK_READY && ping_inc >= cfg.ping_interval_ticks)
            begin
                ev = (pong_inc > cfg.pong_timeout_ticks) ? EV_ABORT : EV_PING;
            end
        end
    end

    always_comb
    begin
        link_phase_next  = link_phase_reg;
        parse_phase_next = parse_phase_reg;
        cand_next        = cand_reg;
        token_count_next = token_count_reg;
        frame_type_next  = frame_type_reg;
        length_next      = length_reg;
        bytes_left_next  = bytes_left_reg;
        idle_ticks_next  = idle_ticks_reg;
        ping_ticks_next  = ping_ticks_reg;
        pong_age_next    = pong_age_reg;

        if (take && link_phase_reg != LINK_DEAD)
        begin
            if (ev == EV_ABORT)
            begin
                link_phase_next = LINK_DEAD;
            end
            else if (is_byte)
            begin
                idle_ticks_next = '0;
                unique case (parse_phase_reg)
                    PH_KEY:
                    begin
                        cand_next = keep;
                        if (is_space)
                        begin
                            frame_type_next  = kw_kind;
                            parse_phase_next = PH_LEN;
                            token_count_next = '0;
                            length_next      = '0;
                        end
                        else
                        begin
                            token_count_next = tok_inc;
                        end
                    end
                    PH_LEN:
                    begin
                        if (is_space)
                        begin
                            bytes_left_next  = length_reg;
                            parse_phase_next = PH_DATA;
                            token_count_next = '0;
                        end
                        else
                        begin
                            length_next      = len_new[LEN_W-1:0];
                            token_count_next = tok_inc;
                        end
                    end
                    PH_DATA:
                    begin
                        bytes_left_next = left_dec;
                        if (left_dec == '0)
                        begin
                            parse_phase_next = PH_KEY;
                            cand_next        = '1;
                            token_count_next = '0;
                            length_next      = '0;
                            if (link_phase_reg == LINK_WAIT)
                            begin
                                link_phase_next = LINK_READY;
                                ping_ticks_next = '0;
                                pong_age_next   = '0;
                            end
                            else if (frame_type_reg == KIND_PONG)
                            begin
                                pong_age_next = '0;
                            end
                        end
                    end
                    default:
                    begin
                        parse_phase_next = parse_phase_reg;
                    end
                endcase
            end
            else
            begin
                if (partial)
                begin
                    idle_ticks_next = idle_inc;
                end
                if (link_phase_reg == LINK_READY)
                begin
                    pong_age_next   = pong_inc;
                    ping_ticks_next = (ping_inc >= cfg.ping_interval_ticks) ? '0 : ping_inc;
                end
            end
        end
    end

    always_comb
    begin
        data_byte   = (link_phase_reg != LINK_DEAD) && is_byte
                      && (parse_phase_reg == PH_DATA) && (ev != EV_ABORT);
        pvalid_next = data_byte;
        pbyte_next  = data_byte ? item.rx_byte : 8'h00;
        kind_next   = data_byte ? frame_type_reg : KIND_PING;
        last_next   = data_byte && (left_dec == '0);

        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_phase_reg  <= LINK_WAIT;
            parse_phase_reg <= PH_KEY;
            cand_reg        <= '1;
            token_count_reg <= '0;
            frame_type_reg  <= KIND_PING;
            length_reg      <= '0;
            bytes_left_reg  <= '0;
            idle_ticks_reg  <= '0;
            ping_ticks_reg  <= '0;
            pong_age_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            link_phase_reg  <= link_phase_next;
            parse_phase_reg <= parse_phase_next;
            cand_reg        <= cand_next;
            token_count_reg <= token_count_next;
            frame_type_reg  <= frame_type_next;
            length_reg      <= length_next;
            bytes_left_reg  <= bytes_left_next;
            idle_ticks_reg  <= idle_ticks_next;
            ping_ticks_reg  <= ping_ticks_next;
            pong_age_reg    <= pong_age_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pvalid_reg <= pvalid_next;
            pbyte_reg  <= pbyte_next;
            kind_reg   <= kind_next;
            last_reg   <= last_next;
            event_reg  <= ev;
        end
    end

    assign out_valid     = out_valid_reg;
    assign payload_valid = pvalid_reg;
    assign payload_byte  = pbyte_reg;
    assign frame_kind    = kind_reg;
    assign last_byte     = last_reg;
    assign event_res     = event_reg;

    a_abort_kills_link: assert property (@(posedge clk) disable iff (!rst_n)
        (take && ev == EV_ABORT) |=> (link_phase_reg == LINK_DEAD))
        else $error("abort request did not close the link");

    a_dead_stays_dead: assert property (@(posedge clk) disable iff (!rst_n)
        (link_phase_reg == LINK_DEAD) |=> (link_phase_reg == LINK_DEAD))
        else $error("link left the aborted state without reset");

    a_ready_sets_link: assert property (@(posedge clk) disable iff (!rst_n)
        (take && ev == EV_READY) |=> (link_phase_reg == LINK_READY))
        else $error("link ready reported but link not ready");

    a_data_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (parse_phase_reg == PH_DATA && link_phase_reg != LINK_DEAD) |-> (bytes_left_reg != '0))
        else $error("payload phase with no bytes left");

    a_last_is_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg) |-> (pvalid_reg && event_reg != EV_ABORT))
        else $error("last byte marked on a request without payload");

endmodule

@@ rtl/core/keyword_length_frame_parser_top.sv @@
// Channel  | Direction | Handshake            | Fields
// ---------+-----------+----------------------+------------------------------------------------
// in       | sink      | in_valid / in_stall  | op, rx_byte
// out      | source    | out_valid / out_stall| payload_valid, payload_byte, frame_kind,
//          |           |                      | last_byte, event_res
// config   | APB slave | psel/penable/pready  | paddr, pwdata, prdata (3 registers, 4-byte stride)
//
// Each request is captured in an input register and resolved in one pass into the result
// register, which presents it; one request is taken per cycle while the result is not
// stalled.
// That rate is set by the combinational parse and timer logic between the two registers.
// Reset clears the link, parser and timer state and loads the default timeout registers.
// A stalled result holds the pipeline; the input register still takes one more request.
module keyword_length_frame_parser_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [klfp_pkg::ADDR_W-1:0]  paddr,
    input  logic [klfp_pkg::DATA_W-1:0]  pwdata,
    output logic [klfp_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         op,
    input  logic [7:0]                   rx_byte,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         payload_valid,
    output logic [7:0]                   payload_byte,
    output logic [2:0]                   frame_kind,
    output logic                         last_byte,
    output logic [2:0]                   event_res
);
    import klfp_pkg::*;

    cfg_t     cfg;
    in_item_t item;
    logic     item_valid;
    logic     take;

    assign pready = 1'b1;

    klfp_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    klfp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .rx_byte    (rx_byte),
        .item_valid (item_valid),
        .item       (item),
        .take       (take)
    );

    klfp_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item          (item),
        .take          (take),
        .cfg           (cfg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .payload_valid (payload_valid),
        .payload_byte  (payload_byte),
        .frame_kind    (frame_kind),
        .last_byte     (last_byte),
        .event_res     (event_res)
    );

endmodule
